[rtl/core/mmul4_pkg.sv]
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
// Used by the channel interfaces, the lanes, the merge stage and the top level.
package mmul4_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int PORT_W         = 32;
    localparam int NUM_LANES      = 4;
    localparam int ROW_SEL_W      = 2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MUL  = 1'b1;

    typedef struct packed {
        logic                     func;
        logic [ROW_SEL_W-1:0]     row_sel;
        logic signed [PORT_W-1:0] elem_a;
        logic signed [PORT_W-1:0] elem_b;
        logic signed [PORT_W-1:0] elem_c;
        logic signed [PORT_W-1:0] elem_d;
    } req_item_t;

    typedef struct packed {
        logic signed [PORT_W-1:0] prod_a;
        logic signed [PORT_W-1:0] prod_b;
        logic signed [PORT_W-1:0] prod_c;
        logic signed [PORT_W-1:0] prod_d;
        logic                     clipped;
    } rsp_item_t;

    // pipeline advance controls, shared by every lane
    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } stage_en_t;

endpackage

[rtl/core/mmul4_req_if.sv]
// Request channel: valid/ready handshake carrying one row item.
// Depends on mmul4_pkg for the payload type.
interface mmul4_req_if;
    logic                  valid;
    logic                  ready;
    mmul4_pkg::req_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/mmul4_rsp_if.sv]
// Response channel: valid/ready handshake carrying one product row.
// Depends on mmul4_pkg for the payload type.
interface mmul4_rsp_if;
    logic                  valid;
    logic                  ready;
    mmul4_pkg::rsp_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/matrix_multiply_4x4_top.sv]
// Row-streamed 4x4 matrix multiplier in signed fixed point (Q16.16 by default).
// A load item writes one row of the stored right matrix in the cycle of its
// transfer and gives no result. A multiply item passes in order through the
// four lanes' product registers, the lane sum registers, and shift and
// saturation into the output register, which gives its product row.
// One item is taken per cycle; a stalled result holds the pipeline behind it.
// Depends on mmul4_pkg, mmul4_req_if, mmul4_rsp_if, mmul4_lane, mmul4_merge.
module matrix_multiply_4x4_top #(
    parameter int ELEM_WIDTH = mmul4_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mmul4_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mmul4_req_if.sink   req,
    mmul4_rsp_if.source rsp
);

    localparam int NL = mmul4_pkg::NUM_LANES;

    logic signed [ELEM_WIDTH-1:0] right_reg [NL][NL];
    logic signed [ELEM_WIDTH-1:0] left [NL];
    logic signed [ELEM_WIDTH-1:0] right_col [NL][NL];
    logic signed [ELEM_WIDTH-1:0] lane_res [NL];
    logic [NL-1:0]                lane_sat;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;

    logic                 out_en;
    logic                 xfer;
    logic                 load_fire;
    logic                 mul_fire;
    mmul4_pkg::stage_en_t ctrl;

    // advance each stage when the one after it is empty or moving
    assign out_en      = ~out_valid_reg | rsp.ready;
    assign ctrl.sum_en = ~s2_valid_reg | out_en;
    assign ctrl.mul_en = ~s1_valid_reg | ctrl.sum_en;
    assign req.ready   = ctrl.mul_en;

    assign xfer      = req.valid & req.ready;
    assign load_fire = xfer & (req.data.func == mmul4_pkg::FUNC_LOAD);
    assign mul_fire  = xfer & (req.data.func == mmul4_pkg::FUNC_MUL);

    assign left[0] = req.data.elem_a[ELEM_WIDTH-1:0];
    assign left[1] = req.data.elem_b[ELEM_WIDTH-1:0];
    assign left[2] = req.data.elem_c[ELEM_WIDTH-1:0];
    assign left[3] = req.data.elem_d[ELEM_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NL; r++)
            begin
                for (int c = 0; c < NL; c++)
                begin
                    right_reg[r][c] <= '0;
                end
            end
        end
        else if (load_fire)
        begin
            right_reg[req.data.row_sel] <= left;
        end
    end

    always_comb
    begin
        s1_valid_next  = ctrl.mul_en ? mul_fire : s1_valid_reg;
        s2_valid_next  = ctrl.sum_en ? s1_valid_reg : s2_valid_reg;
        out_valid_next = out_en ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    for (genvar j = 0; j < NL; j++)
    begin : g_lane
        for (genvar k = 0; k < NL; k++)
        begin : g_col
            assign right_col[j][k] = right_reg[k][j];
        end

        mmul4_lane #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .ctrl      (ctrl),
            .left      (left),
            .right_col (right_col[j]),
            .res       (lane_res[j]),
            .sat       (lane_sat[j])
        );
    end

    mmul4_merge #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_merge (
        .clk      (clk),
        .load_en  (out_en),
        .lane_res (lane_res),
        .lane_sat (lane_sat),
        .row      (rsp.data)
    );

    assign rsp.valid = out_valid_reg;

endmodule

[rtl/core/mmul4_lane.sv]
// One dot-product lane: four registered products, a registered sum, then
// arithmetic shift and saturation. Depends on mmul4_pkg.
module mmul4_lane #(
    parameter int ELEM_WIDTH = mmul4_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = mmul4_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  mmul4_pkg::stage_en_t         ctrl,
    input  logic signed [ELEM_WIDTH-1:0] left [mmul4_pkg::NUM_LANES],
    input  logic signed [ELEM_WIDTH-1:0] right_col [mmul4_pkg::NUM_LANES],
    output logic signed [ELEM_WIDTH-1:0] res,
    output logic                         sat
);

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int TOP_W  = SUM_W - ELEM_WIDTH + 1;

    localparam logic signed [ELEM_WIDTH-1:0] MAX_VAL = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam logic signed [ELEM_WIDTH-1:0] MIN_VAL = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_next [mmul4_pkg::NUM_LANES];
    logic signed [PROD_W-1:0] prod_reg  [mmul4_pkg::NUM_LANES];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  shifted;
    logic [TOP_W-1:0]         top_bits;
    logic                     fits;

    always_comb
    begin
        for (int k = 0; k < mmul4_pkg::NUM_LANES; k++)
        begin
            prod_next[k] = left[k] * right_col[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1])
                    + SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]);

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    // clamp when the bits above the result's sign differ from it
    assign shifted  = sum_reg >>> FRAC_BITS;
    assign top_bits = shifted[SUM_W-1:ELEM_WIDTH-1];
    assign fits     = (&top_bits) | ~(|top_bits);

    always_comb
    begin
        sat = ~fits;
        if (fits)
        begin
            res = shifted[ELEM_WIDTH-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            res = MIN_VAL;
        end
        else
        begin
            res = MAX_VAL;
        end
    end

endmodule

[rtl/core/mmul4_merge.sv]
// Merge stage: widens the lane results to the port format, combines the
// saturation flags and holds the result row. Depends on mmul4_pkg.
module mmul4_merge #(
    parameter int ELEM_WIDTH = mmul4_pkg::ELEM_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         load_en,
    input  logic signed [ELEM_WIDTH-1:0] lane_res [mmul4_pkg::NUM_LANES],
    input  logic [mmul4_pkg::NUM_LANES-1:0] lane_sat,
    output mmul4_pkg::rsp_item_t         row
);

    mmul4_pkg::rsp_item_t row_next;
    mmul4_pkg::rsp_item_t row_reg;

    always_comb
    begin
        row_next.prod_a  = mmul4_pkg::PORT_W'(lane_res[0]);
        row_next.prod_b  = mmul4_pkg::PORT_W'(lane_res[1]);
        row_next.prod_c  = mmul4_pkg::PORT_W'(lane_res[2]);
        row_next.prod_d  = mmul4_pkg::PORT_W'(lane_res[3]);
        row_next.clipped = |lane_sat;
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            row_reg <= row_next;
        end
    end

    assign row = row_reg;

endmodule

[bench/matrix_multiply_4x4_top_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for matrix_multiply_4x4_top: directed rows, then random rows.
// Product rows are checked against a Q16.16 row-times-matrix predictor, or against fixed rows for typed steps.
// Depends on mmul4_pkg, mmul4_req_if, mmul4_rsp_if and the multiplier RTL.
module matrix_multiply_4x4_top_test;

    localparam logic [mmul4_pkg::PORT_W-1:0] ONE_Q    = 32'h0001_0000;
    localparam logic [mmul4_pkg::PORT_W-1:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [mmul4_pkg::PORT_W-1:0] NEG_MAX  = 32'h8000_0000;
    localparam logic [mmul4_pkg::PORT_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic signed [67:0] SUM_MAX = (68'sd1 <<< (mmul4_pkg::PORT_W - 1)) - 68'sd1;
    localparam logic signed [67:0] SUM_MIN = -(68'sd1 <<< (mmul4_pkg::PORT_W - 1));
    localparam int RANDOM_ROWS = 1900;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        mmul4_pkg::req_item_t item;
        bit                   typed;
        mmul4_pkg::rsp_item_t want;
    } plan_step_t;

    logic clk = 1'b0;
    logic rst_n;

    mmul4_req_if req_ch ();
    mmul4_rsp_if rsp_ch ();

    matrix_multiply_4x4_top #(
        .ELEM_WIDTH (mmul4_pkg::ELEM_WIDTH_DEF),
        .FRAC_BITS  (mmul4_pkg::FRAC_BITS_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic signed [mmul4_pkg::PORT_W-1:0] right_rows [4][4];
    mmul4_pkg::rsp_item_t expected_products [$];
    plan_step_t           directed_plan [$];
    int                   fault_count = 0;
    int                   send_run = 0;
    int                   take_run = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            run_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 13);
    endfunction

    function automatic mmul4_pkg::rsp_item_t row_times_right(mmul4_pkg::req_item_t it);
        longint                              left [4];
        logic signed [67:0]                  acc;
        logic signed [67:0]                  shifted;
        logic signed [mmul4_pkg::PORT_W-1:0] lane [4];
        mmul4_pkg::rsp_item_t                r;
        left[0] = longint'($signed(it.elem_a));
        left[1] = longint'($signed(it.elem_b));
        left[2] = longint'($signed(it.elem_c));
        left[3] = longint'($signed(it.elem_d));
        r = '0;
        for (int j = 0; j < 4; j++)
        begin
            acc = '0;
            for (int k = 0; k < 4; k++)
                acc = acc + left[k] * longint'(right_rows[k][j]);
            shifted = acc >>> mmul4_pkg::FRAC_BITS_DEF;
            if (shifted > SUM_MAX)
            begin
                lane[j] = POS_MAX;
                r.clipped = 1'b1;
            end
            else if (shifted < SUM_MIN)
            begin
                lane[j] = NEG_MAX;
                r.clipped = 1'b1;
            end
            else
                lane[j] = shifted[mmul4_pkg::PORT_W-1:0];
        end
        r.prod_a = lane[0];
        r.prod_b = lane[1];
        r.prod_c = lane[2];
        r.prod_d = lane[3];
        return r;
    endfunction

    function automatic logic [mmul4_pkg::PORT_W-1:0] pick_elem();
        logic [mmul4_pkg::PORT_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            7, 8:       v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       v = POS_MAX;
                    1:       v = NEG_MAX;
                    2:       v = '0;
                    3:       v = ALL_ONES;
                    4:       v = 32'h0000_0001;
                    default: v = ONE_Q;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic add_step(input logic f, input logic [1:0] sel,
                            input logic [mmul4_pkg::PORT_W-1:0] a, b, c, d,
                            input bit typed,
                            input logic [mmul4_pkg::PORT_W-1:0] pa, pb, pc, pd,
                            input logic clip);
        plan_step_t s;
        s.item.func    = f;
        s.item.row_sel = sel;
        s.item.elem_a  = a;
        s.item.elem_b  = b;
        s.item.elem_c  = c;
        s.item.elem_d  = d;
        s.typed        = typed;
        s.want.prod_a  = pa;
        s.want.prod_b  = pb;
        s.want.prod_c  = pc;
        s.want.prod_d  = pd;
        s.want.clipped = clip;
        directed_plan.push_back(s);
    endtask

    task automatic send_row(input mmul4_pkg::req_item_t it, input bit typed,
                            input mmul4_pkg::rsp_item_t want);
        int gap;
        gap = draw_wait(send_run);
        repeat (gap)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        if (it.func == mmul4_pkg::FUNC_LOAD)
        begin
            right_rows[it.row_sel][0] = it.elem_a;
            right_rows[it.row_sel][1] = it.elem_b;
            right_rows[it.row_sel][2] = it.elem_c;
            right_rows[it.row_sel][3] = it.elem_d;
        end
        else if (typed)
            expected_products.push_back(want);
        else
            expected_products.push_back(row_times_right(it));
    endtask

    task automatic drain_products();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_products.size() != 0)
            @(posedge clk);
    endtask

    // response side: random stalls, field-by-field check against the oldest expectation
    initial
    begin
        int                           gap;
        mmul4_pkg::rsp_item_t         got;
        mmul4_pkg::rsp_item_t         want;
        logic [mmul4_pkg::PORT_W-1:0] got_f [5];
        logic [mmul4_pkg::PORT_W-1:0] want_f [5];
        string                        field_name [5];
        field_name = '{"prod_a", "prod_b", "prod_c", "prod_d", "clipped"};
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_wait(take_run);
            repeat (gap)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            got = rsp_ch.data;
            if (expected_products.size() == 0)
            begin
                fault_count++;
                $display("%0t: product row with none expected: %h", $realtime, got);
            end
            else
            begin
                want = expected_products.pop_front();
                got_f  = '{got.prod_a, got.prod_b, got.prod_c, got.prod_d,
                           {{(mmul4_pkg::PORT_W-1){1'b0}}, got.clipped}};
                want_f = '{want.prod_a, want.prod_b, want.prod_c, want.prod_d,
                           {{(mmul4_pkg::PORT_W-1){1'b0}}, want.clipped}};
                for (int i = 0; i < 5; i++)
                begin
                    if (got_f[i] !== want_f[i])
                    begin
                        fault_count++;
                        $display("%0t: %s expected %h actual %h", $realtime,
                                 field_name[i], want_f[i], got_f[i]);
                    end
                end
            end
        end
    end

    initial
    begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        mmul4_pkg::req_item_t it;
        mmul4_pkg::rsp_item_t none;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        none         = '0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                right_rows[r][c] = '0;

        // zero matrix after reset
        add_step(mmul4_pkg::FUNC_MUL, 2'd0, POS_MAX, NEG_MAX, ALL_ONES, 32'h1,
                 1, 0, 0, 0, 0, 1'b0);
        // identity in Q16.16 passes the row through, row_sel ignored on multiply
        add_step(mmul4_pkg::FUNC_LOAD, 2'd0, ONE_Q, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_step(mmul4_pkg::FUNC_LOAD, 2'd1, 0, ONE_Q, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_step(mmul4_pkg::FUNC_LOAD, 2'd2, 0, 0, ONE_Q, 0, 0, 0, 0, 0, 0, 1'b0);
        add_step(mmul4_pkg::FUNC_LOAD, 2'd3, 0, 0, 0, ONE_Q, 0, 0, 0, 0, 0, 1'b0);
        add_step(mmul4_pkg::FUNC_MUL, 2'd3, POS_MAX, NEG_MAX, ALL_ONES, 32'h1,
                 1, POS_MAX, NEG_MAX, ALL_ONES, 32'h1, 1'b0);
        // largest positive everywhere: saturation both ways
        for (int r = 0; r < 4; r++)
            add_step(mmul4_pkg::FUNC_LOAD, 2'(r), POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                     0, 0, 0, 0, 0, 1'b0);
        add_step(mmul4_pkg::FUNC_MUL, 2'd0, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                 1, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b1);
        add_step(mmul4_pkg::FUNC_MUL, 2'd1, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX,
                 1, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, 1'b1);
        add_step(mmul4_pkg::FUNC_MUL, 2'd2, 0, 0, 0, 0, 1, 0, 0, 0, 0, 1'b0);
        // shift rounds toward minus infinity
        add_step(mmul4_pkg::FUNC_MUL, 2'd0, ALL_ONES, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_step(mmul4_pkg::FUNC_MUL, 2'd0, 32'h1, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        // most negative everywhere
        for (int r = 0; r < 4; r++)
            add_step(mmul4_pkg::FUNC_LOAD, 2'(r), NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX,
                     0, 0, 0, 0, 0, 1'b0);
        add_step(mmul4_pkg::FUNC_MUL, 2'd3, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX,
                 1, POS_MAX, POS_MAX, POS_MAX, POS_MAX, 1'b1);
        add_step(mmul4_pkg::FUNC_MUL, 2'd2, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                 1, NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX, 1'b1);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
            send_row(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);
        drain_products();

        for (int n = 0; n < RANDOM_ROWS; n++)
        begin
            it.func    = ($urandom_range(0, 2) == 0) ? mmul4_pkg::FUNC_LOAD
                                                     : mmul4_pkg::FUNC_MUL;
            it.row_sel = 2'($urandom_range(0, 3));
            it.elem_a  = pick_elem();
            it.elem_b  = pick_elem();
            it.elem_c  = pick_elem();
            it.elem_d  = pick_elem();
            send_row(it, 0, none);
            if (n % 400 == 399)
                drain_products();
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
